// ----- hdl/ppw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_pkg
// shared constants, register indexes and types for the perspective point warp
// ----------------------------------------------------------------------------
package ppw_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH      = 32;
    localparam int COORD_FRAC      = 4;
    localparam int NUM_FRAC        = 16 + COORD_FRAC;
    localparam int DEN_FRAC        = 28 + COORD_FRAC;
    localparam int OUT_SHIFT       = DEN_FRAC + COORD_FRAC - NUM_FRAC;
    localparam int NUM_REGS        = 8;
    localparam int INDEX_WIDTH     = 3;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_A = 3'd0,
        REG_B = 3'd1,
        REG_C = 3'd2,
        REG_D = 3'd3,
        REG_E = 3'd4,
        REG_F = 3'd5,
        REG_I = 3'd6,
        REG_J = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [COEF_WIDTH-1:0] c;
        logic signed [COEF_WIDTH-1:0] d;
        logic signed [COEF_WIDTH-1:0] e;
        logic signed [COEF_WIDTH-1:0] f;
        logic signed [COEF_WIDTH-1:0] i;
        logic signed [COEF_WIDTH-1:0] j;
    } coef_set_t;

endpackage

// ----- hdl/ppw_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_sum
// products and sums of the numerators and the denominator, two stages
// ----------------------------------------------------------------------------
module ppw_sum #(
    parameter int COORD_WIDTH = ppw_pkg::COORD_WIDTH_DEF,
    parameter int SUM_WIDTH   = ppw_pkg::COEF_WIDTH + COORD_WIDTH + 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  ppw_pkg::coef_set_t          coefs,
    output logic                        out_valid,
    output logic signed [SUM_WIDTH-1:0] nx,
    output logic signed [SUM_WIDTH-1:0] ny,
    output logic signed [SUM_WIDTH-1:0] den
);
    localparam int PW = ppw_pkg::COEF_WIDTH + COORD_WIDTH;

    logic signed [PW-1:0] p_ax_reg, p_by_reg, p_dx_reg, p_ey_reg, p_ix_reg, p_jy_reg;
    logic signed [PW-1:0] p_c_reg, p_f_reg;
    logic                 v1_reg, v2_reg;
    logic signed [SUM_WIDTH-1:0] nx_reg, ny_reg, den_reg;
    logic signed [SUM_WIDTH-1:0] one;

    assign one = SUM_WIDTH'(64'sd1) <<< ppw_pkg::DEN_FRAC;

    // stage 1: one multiplier per product, operands widened to the full product
    always_ff @(posedge clk)
    begin
        p_ax_reg <= PW'(coefs.a) * PW'(x_in);
        p_by_reg <= PW'(coefs.b) * PW'(y_in);
        p_dx_reg <= PW'(coefs.d) * PW'(x_in);
        p_ey_reg <= PW'(coefs.e) * PW'(y_in);
        p_ix_reg <= PW'(coefs.i) * PW'(x_in);
        p_jy_reg <= PW'(coefs.j) * PW'(y_in);
        p_c_reg  <= PW'(coefs.c) <<< ppw_pkg::COORD_FRAC;
        p_f_reg  <= PW'(coefs.f) <<< ppw_pkg::COORD_FRAC;
    end

    // stage 2: three-term sums
    always_ff @(posedge clk)
    begin
        nx_reg  <= SUM_WIDTH'(p_ax_reg) + SUM_WIDTH'(p_by_reg) + SUM_WIDTH'(p_c_reg);
        ny_reg  <= SUM_WIDTH'(p_dx_reg) + SUM_WIDTH'(p_ey_reg) + SUM_WIDTH'(p_f_reg);
        den_reg <= SUM_WIDTH'(p_ix_reg) + SUM_WIDTH'(p_jy_reg) + one;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign nx        = nx_reg;
    assign ny        = ny_reg;
    assign den       = den_reg;
endmodule

// ----- hdl/ppw_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_div
// pipelined restoring divider, rounded and saturated quotient, one bit a stage
// ----------------------------------------------------------------------------
module ppw_div #(
    parameter int COORD_WIDTH = ppw_pkg::COORD_WIDTH_DEF,
    parameter int SUM_WIDTH   = ppw_pkg::COEF_WIDTH + COORD_WIDTH + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [SUM_WIDTH-1:0]   num,
    input  logic signed [SUM_WIDTH-1:0]   den,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] quo,
    output logic                          clip
);
    // quotient bits: COORD_WIDTH magnitude bits plus one overflow bit
    localparam int QB = COORD_WIDTH + 1;
    localparam int DW = SUM_WIDTH + 1;
    // dividend magnitude scaled: 2^(shift+1)*|n| + |d|, remainder width
    localparam int RW = DW + QB + 1;
    localparam int NW = SUM_WIDTH + ppw_pkg::OUT_SHIFT + 2;

    // stage 0 prepares magnitudes
    logic [NW-1:0]   top_reg;
    logic [DW-1:0]   d2_reg;
    logic            neg0_reg, v0_reg;
    logic [SUM_WIDTH-1:0] an, ad;

    assign an = num[SUM_WIDTH-1] ? SUM_WIDTH'(-num) : SUM_WIDTH'(num);
    assign ad = den[SUM_WIDTH-1] ? SUM_WIDTH'(-den) : SUM_WIDTH'(den);

    always_ff @(posedge clk)
    begin
        top_reg  <= (NW'(an) << (ppw_pkg::OUT_SHIFT + 1)) + NW'(ad);
        d2_reg   <= DW'(ad) << 1;
        neg0_reg <= num[SUM_WIDTH-1] ^ den[SUM_WIDTH-1];
    end

    // high part of the dividend: quotient saturates when it reaches d2 at the top
    logic          ovf0;
    assign ovf0 = (top_reg >> QB) >= NW'(d2_reg);

    // division stages, one quotient bit each
    logic [RW-1:0] rem_reg [QB+1];
    logic [NW-1:0] dvd_reg [QB+1];
    logic [DW-1:0] dsr_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ng_reg  [QB+1];
    logic          of_reg  [QB+1];
    logic          vv_reg  [QB+1];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= RW'(top_reg >> QB);
        dvd_reg[0] <= top_reg;
        dsr_reg[0] <= d2_reg;
        q_reg[0]   <= '0;
        ng_reg[0]  <= neg0_reg;
        of_reg[0]  <= ovf0;
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        logic [RW-1:0] trial;
        logic          fit;
        assign trial = {rem_reg[s][RW-2:0], dvd_reg[s][QB-1-s]};
        assign fit   = trial >= RW'(dsr_reg[s]);
        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= fit ? RW'(trial - RW'(dsr_reg[s])) : trial;
            dvd_reg[s+1] <= dvd_reg[s];
            dsr_reg[s+1] <= dsr_reg[s];
            q_reg[s+1]   <= {q_reg[s][QB-2:0], fit};
            ng_reg[s+1]  <= ng_reg[s];
            of_reg[s+1]  <= of_reg[s];
        end
    end

    // valid bits through every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int k = 0; k <= QB; k++)
                vv_reg[k] <= 1'b0;
        end
        else
        begin
            v0_reg    <= in_valid;
            vv_reg[0] <= v0_reg;
            for (int k = 0; k < QB; k++)
                vv_reg[k+1] <= vv_reg[k];
        end
    end

    // saturate and apply sign
    logic [QB-1:0] lim;
    logic          sat;
    logic [QB-1:0] mag;
    assign lim = (QB'(1) << (COORD_WIDTH - 1)) - (ng_reg[QB] ? QB'(0) : QB'(1));
    assign sat = of_reg[QB] || (q_reg[QB] > lim);
    assign mag = sat ? lim : q_reg[QB];

    assign quo       = COORD_WIDTH'(ng_reg[QB] ? QB'(-mag) : mag);
    assign clip      = sat;
    assign out_valid = vv_reg[QB];
endmodule

// ----- hdl/perspective_point_warp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_warp_top
// homography point warp with rounded, saturated Q12.4 outputs
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// command   in         start & !busy       x_in, y_in
// config    in         cfg_valid & ready   cfg_index, cfg_data
// result    out        done strobe         x_out, y_out, clipped, denom_zero
//
// one point per clock; the one-bit-per-stage divider follows the two multiply
// and sum stages, and the result is registered at the output.
// reset clears all valid bits and loads the identity matrix.
// busy is always low and cfg_ready always high; results cannot be stalled.
// ----------------------------------------------------------------------------
module perspective_point_warp_top #(
    parameter int COORD_WIDTH = ppw_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppw_pkg::INDEX_WIDTH:0] cfg_index,
    input  logic [ppw_pkg::COEF_WIDTH-1:0] cfg_data,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic                          clipped,
    output logic                          denom_zero
);
    localparam int SW = ppw_pkg::COEF_WIDTH + COORD_WIDTH + 3;
    localparam int LAT = COORD_WIDTH + 3;

    ppw_pkg::coef_set_t coef_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '{a: 32'sd65536, b: '0, c: '0, d: '0,
                          e: 32'sd65536, f: '0, i: '0, j: '0};
        end
        else if (cfg_valid && !cfg_index[ppw_pkg::INDEX_WIDTH])
        begin
            case (ppw_pkg::reg_index_t'(cfg_index[ppw_pkg::INDEX_WIDTH-1:0]))
                ppw_pkg::REG_A: coef_reg.a <= cfg_data;
                ppw_pkg::REG_B: coef_reg.b <= cfg_data;
                ppw_pkg::REG_C: coef_reg.c <= cfg_data;
                ppw_pkg::REG_D: coef_reg.d <= cfg_data;
                ppw_pkg::REG_E: coef_reg.e <= cfg_data;
                ppw_pkg::REG_F: coef_reg.f <= cfg_data;
                ppw_pkg::REG_I: coef_reg.i <= cfg_data;
                ppw_pkg::REG_J: coef_reg.j <= cfg_data;
                default: coef_reg <= coef_reg;
            endcase
        end
    end

    logic                 s_valid;
    logic signed [SW-1:0] nx, ny, den;

    ppw_sum #(.COORD_WIDTH(COORD_WIDTH), .SUM_WIDTH(SW)) u_sum (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .x_in(x_in), .y_in(y_in),
        .coefs(coef_reg), .out_valid(s_valid), .nx(nx), .ny(ny), .den(den)
    );

    logic                          vx, vy, cx, cy;
    logic signed [COORD_WIDTH-1:0] qx, qy;

    ppw_div #(.COORD_WIDTH(COORD_WIDTH), .SUM_WIDTH(SW)) u_div_x (
        .clk(clk), .rst_n(rst_n), .in_valid(s_valid), .num(nx), .den(den),
        .out_valid(vx), .quo(qx), .clip(cx)
    );

    ppw_div #(.COORD_WIDTH(COORD_WIDTH), .SUM_WIDTH(SW)) u_div_y (
        .clk(clk), .rst_n(rst_n), .in_valid(s_valid), .num(ny), .den(den),
        .out_valid(vy), .quo(qy), .clip(cy)
    );

    // zero-denominator flag delayed alongside the dividers
    logic zd_reg [LAT];
    always_ff @(posedge clk)
    begin
        zd_reg[0] <= (den == '0);
        for (int k = 1; k < LAT; k++)
            zd_reg[k] <= zd_reg[k-1];
    end

    // output register
    logic                          done_reg, clip_reg, dz_reg;
    logic signed [COORD_WIDTH-1:0] xo_reg, yo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vx;
    end

    always_ff @(posedge clk)
    begin
        dz_reg   <= zd_reg[LAT-1];
        xo_reg   <= zd_reg[LAT-1] ? '0 : qx;
        yo_reg   <= zd_reg[LAT-1] ? '0 : qy;
        clip_reg <= !zd_reg[LAT-1] && (cx || cy);
    end

    assign done       = done_reg;
    assign x_out      = xo_reg;
    assign y_out      = yo_reg;
    assign clipped    = clip_reg;
    assign denom_zero = dz_reg;

    // both dividers stay in step
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n) vx == vy)
        else $error("divider lanes out of step");
    // zero denominator forces zero outputs
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && denom_zero |-> x_out == '0 && y_out == '0 && !clipped)
        else $error("zero denominator output not cleared");
    // fixed latency from accept to result
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(COORD_WIDTH + 6) done)
        else $error("result missing after fixed latency");
endmodule

// ----- tb/perspective_point_warp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_warp_checker
// watches the command, config and result channels of the point warp, keeps
// its own coefficient set, predicts each warped point and compares in order
// ----------------------------------------------------------------------------
module perspective_point_warp_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   x_in,
    input  logic signed [COORD_WIDTH-1:0]   y_in,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ppw_pkg::INDEX_WIDTH:0]   cfg_index,
    input  logic [ppw_pkg::COEF_WIDTH-1:0]  cfg_data,
    input  logic                            done,
    input  logic signed [COORD_WIDTH-1:0]   x_out,
    input  logic signed [COORD_WIDTH-1:0]   y_out,
    input  logic                            clipped,
    input  logic                            denom_zero,
    output int                              fail_count,
    output int                              pending
);
    typedef struct packed {
        logic [COORD_WIDTH-1:0] xw;
        logic [COORD_WIDTH-1:0] yw;
        logic                   clip;
        logic                   dz;
    } warp_t;

    logic signed [ppw_pkg::COEF_WIDTH-1:0] coefs [ppw_pkg::NUM_REGS];
    warp_t warp_q [$];

    // rounded, saturated quotient magnitude with sign; sets clip on saturation
    function automatic logic [COORD_WIDTH-1:0] warp_div(input logic signed [127:0] num,
                                                       input logic signed [127:0] den,
                                                       inout logic clip);
        logic                 neg;
        logic [127:0]         an;
        logic [127:0]         ad;
        logic [127:0]         q;
        logic [127:0]         lim;
        logic [127:0]         mag;
        neg = num[127] != den[127];
        an  = num[127] ? -num : num;
        ad  = den[127] ? -den : den;
        q   = ((an << (ppw_pkg::OUT_SHIFT + 1)) + ad) / (ad << 1);
        lim = (128'd1 << (COORD_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
        mag = q;
        if (q > lim)
        begin
            mag  = lim;
            clip = 1'b1;
        end
        if (neg)
            mag = -mag;
        return mag[COORD_WIDTH-1:0];
    endfunction

    function automatic warp_t warp_point(input logic signed [COORD_WIDTH-1:0] px,
                                         input logic signed [COORD_WIDTH-1:0] py);
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic signed [127:0] den;
        logic signed [127:0] nx;
        logic signed [127:0] ny;
        warp_t               w;
        x   = px;
        y   = py;
        den = 128'(coefs[ppw_pkg::REG_I]) * x + 128'(coefs[ppw_pkg::REG_J]) * y
            + (128'sd1 <<< ppw_pkg::DEN_FRAC);
        nx  = 128'(coefs[ppw_pkg::REG_A]) * x + 128'(coefs[ppw_pkg::REG_B]) * y
            + 128'(coefs[ppw_pkg::REG_C]) * (128'sd1 <<< ppw_pkg::COORD_FRAC);
        ny  = 128'(coefs[ppw_pkg::REG_D]) * x + 128'(coefs[ppw_pkg::REG_E]) * y
            + 128'(coefs[ppw_pkg::REG_F]) * (128'sd1 <<< ppw_pkg::COORD_FRAC);
        w = '0;
        if (den == 0)
            w.dz = 1'b1;
        else
        begin
            w.xw = warp_div(nx, den, w.clip);
            w.yw = warp_div(ny, den, w.clip);
        end
        return w;
    endfunction

    // track coefficients, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        warp_t exp_w;
        if (!rst_n)
        begin
            coefs[ppw_pkg::REG_A] <= 32'sd65536;
            coefs[ppw_pkg::REG_B] <= '0;
            coefs[ppw_pkg::REG_C] <= '0;
            coefs[ppw_pkg::REG_D] <= '0;
            coefs[ppw_pkg::REG_E] <= 32'sd65536;
            coefs[ppw_pkg::REG_F] <= '0;
            coefs[ppw_pkg::REG_I] <= '0;
            coefs[ppw_pkg::REG_J] <= '0;
            warp_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (start && !busy)
                warp_q.push_back(warp_point(x_in, y_in));
            if (done)
            begin
                if (warp_q.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = warp_q.pop_front();
                    if (x_out !== exp_w.xw || y_out !== exp_w.yw
                        || clipped !== exp_w.clip || denom_zero !== exp_w.dz)
                        fail_count <= fail_count + 1;
                    if (x_out !== exp_w.xw)
                        $error("x_out expected %0d actual %0d",
                               $signed(exp_w.xw), x_out);
                    if (y_out !== exp_w.yw)
                        $error("y_out expected %0d actual %0d",
                               $signed(exp_w.yw), y_out);
                    if (clipped !== exp_w.clip)
                        $error("clipped expected %0b actual %0b", exp_w.clip, clipped);
                    if (denom_zero !== exp_w.dz)
                        $error("denom_zero expected %0b actual %0b",
                               exp_w.dz, denom_zero);
                end
            end
            pending <= warp_q.size();
            // out-of-range index is ignored
            if (cfg_valid && cfg_ready && cfg_index < ppw_pkg::NUM_REGS)
                coefs[cfg_index[ppw_pkg::INDEX_WIDTH-1:0]] <= cfg_data;
        end
    end
endmodule

// ----- tb/perspective_point_warp_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_warp_top_test
// drives bursts of points through the warp under a series of coefficient
// sets, from identity to full-scale extremes; the checker does the compare
// ----------------------------------------------------------------------------
module perspective_point_warp_top_test;
    localparam int CW        = 16;
    localparam int LATENCY   = CW + 6;
    localparam int MAX_CYCLE = 400000;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic signed [CW-1:0]            x_in;
    logic signed [CW-1:0]            y_in;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [ppw_pkg::INDEX_WIDTH:0]   cfg_index;
    logic [ppw_pkg::COEF_WIDTH-1:0]  cfg_data;
    logic                            done;
    logic signed [CW-1:0]            x_out;
    logic signed [CW-1:0]            y_out;
    logic                            clipped;
    logic                            denom_zero;
    int                              fail_count;
    int                              pending;
    int                              cycle_count = 0;

    perspective_point_warp_top #(.COORD_WIDTH(CW)) i_dut (.*);

    perspective_point_warp_checker #(.COORD_WIDTH(CW)) i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_coef(input logic [ppw_pkg::INDEX_WIDTH:0] idx,
                              input logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one command transaction; start stays high across back-to-back points
    task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                              input bit keep);
        start = 1'b1;
        x_in  = px;
        y_in  = py;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (!keep)
            start = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coef(input int mode);
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 262143)) - 131072);
            default: return (mode == 0) ? 32'($signed($urandom_range(0, 8191)) - 4096)
                                        : $urandom();
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return CW'($urandom());
        endcase
    endfunction

    // random bursts of points with random gaps, sometimes gap-free
    task automatic random_points(input int n);
        int burst;
        int k;
        bit no_gap;
        k = 0;
        no_gap = ($urandom_range(0, 3) == 0);
        while (k < n)
        begin
            burst = $urandom_range(1, 24);
            for (int m = 0; m < burst && k < n; m++)
            begin
                send_point(pick_coord(), pick_coord(), m != burst - 1 && k != n - 1);
                k++;
            end
            if (!no_gap)
                repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] ci;
        logic [31:0] cj;
        rst_n     = 1'b0;
        start     = 1'b0;
        x_in      = '0;
        y_in      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: identity at reset, field extremes
        send_point(16'h0000, 16'h0000, 1);
        send_point(16'h7FFF, 16'h8000, 1);
        send_point(16'h8000, 16'h7FFF, 1);
        send_point(16'hFFFF, 16'h0001, 0);
        drain();

        // scales 2.5 and -2.5 with offsets: saturation both ways, rounding near ties
        write_coef(4'(ppw_pkg::REG_A), 32'h0002_8000);
        write_coef(4'(ppw_pkg::REG_E), 32'hFFFD_8000);
        write_coef(4'(ppw_pkg::REG_C), 32'h0000_0008);
        write_coef(4'(ppw_pkg::REG_F), 32'hFFFF_FFF8);
        write_coef(4'd8, 32'hDEAD_BEEF);
        write_coef(4'd15, 32'h1234_5678);
        send_point(16'h7FFF, 16'h7FFF, 1);
        send_point(16'h8000, 16'h8000, 1);
        send_point(16'h0001, 16'h0003, 1);
        send_point(16'hFFFF, 16'hFFFD, 0);
        drain();

        // zero denominator: i*x = -1 at x = 1.0 with i = -1.0 (Q4.28 / Q12.4)
        write_coef(4'(ppw_pkg::REG_I), 32'hF000_0000);
        write_coef(4'(ppw_pkg::REG_J), 32'h0000_0000);
        write_coef(4'(ppw_pkg::REG_B), 32'h0001_0000);
        write_coef(4'(ppw_pkg::REG_D), 32'hFFFF_0000);
        send_point(16'd16, 16'd5, 1);
        send_point(16'd32, 16'd5, 1);
        send_point(16'd48, 16'h8000, 1);
        send_point(16'd0, 16'd0, 0);
        drain();

        // negative denominator via j, and denominator zero through j
        write_coef(4'(ppw_pkg::REG_J), 32'h0100_0000);
        send_point(16'd0, 16'hFFF0, 1);
        send_point(16'd0, 16'hFF00, 1);
        send_point(16'h7FFF, 16'h8000, 0);
        drain();

        // phases of random coefficient sets, full-range and mild
        for (int ph = 0; ph < 16; ph++)
        begin
            for (int r = 0; r < 6; r++)
                write_coef(4'(r), pick_coef(ph % 2));
            ci = (ph % 4 == 3) ? 32'h8000_0000 : (ph % 4 == 2) ? 32'h7FFF_FFFF
                 : 32'($signed($urandom_range(0, 65535)) - 32768) <<< ($urandom_range(0, 12));
            cj = (ph % 4 == 3) ? 32'h7FFF_FFFF : (ph % 4 == 1) ? $urandom()
                 : 32'($signed($urandom_range(0, 65535)) - 32768) <<< ($urandom_range(0, 12));
            write_coef(4'(ppw_pkg::REG_I), ci);
            write_coef(4'(ppw_pkg::REG_J), cj);
            random_points(125);
            drain();
        end

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/ppw_pkg.sv
hdl/ppw_sum.sv
hdl/ppw_div.sv
hdl/perspective_point_warp_top.sv
tb/perspective_point_warp_checker.sv
tb/perspective_point_warp_top_test.sv
